// ----- src/icpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package icpd_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [3:0] OFF_BASIC_PEND    = 4'd0;
    localparam logic [3:0] OFF_PEND_BANK1    = 4'd1;
    localparam logic [3:0] OFF_PEND_BANK2    = 4'd2;
    localparam logic [3:0] OFF_ENABLE_BANK1  = 4'd4;
    localparam logic [3:0] OFF_ENABLE_BANK2  = 4'd5;
    localparam logic [3:0] OFF_ENABLE_BASIC  = 4'd6;
    localparam logic [3:0] OFF_DISABLE_BANK1 = 4'd7;
    localparam logic [3:0] OFF_DISABLE_BANK2 = 4'd8;
    localparam logic [3:0] OFF_DISABLE_BASIC = 4'd9;

    localparam int SC_COUNT = 11;

    localparam logic [6:0] SC_SOURCE [SC_COUNT] = '{
        7'd7, 7'd9, 7'd10, 7'd18, 7'd19, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd62
    };

    localparam logic [31:0] SC_IN_BANK1 = 32'h000c_0680;
    localparam logic [31:0] SC_IN_BANK2 = 32'h43e0_0000;

    typedef struct packed {
        logic [31:0] bank1;
        logic [31:0] bank2;
        logic [7:0]  basic;
    } enable_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_out;
        logic [6:0]  next_irq;
        logic        next_valid;
    } result_t;

    // Index of the highest set bit, found by halving the word five times.
    function automatic logic [4:0] top_bit32(logic [31:0] v);
        logic [31:0] w;
        logic [4:0]  n;
        w = v;
        n = '0;
        if (w[31:16] != '0)
        begin
            n[4] = 1'b1;
            w    = w >> 16;
        end
        if (w[15:8] != '0)
        begin
            n[3] = 1'b1;
            w    = w >> 8;
        end
        if (w[7:4] != '0)
        begin
            n[2] = 1'b1;
            w    = w >> 4;
        end
        if (w[3:2] != '0)
        begin
            n[1] = 1'b1;
            w    = w >> 2;
        end
        if (w[1])
        begin
            n[0] = 1'b1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// ----- src/icpd_enable_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module icpd_enable_regs (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            commit,
    input  wire logic            op,
    input  wire logic [3:0]      reg_offset,
    input  wire logic [31:0]     write_data,
    output icpd_pkg::enable_t    enable_next
);
    import icpd_pkg::*;

    enable_t enable_reg;

    always_comb
    begin
        enable_next = enable_reg;
        if (op == OP_WRITE)
        begin
            unique case (reg_offset)
                OFF_ENABLE_BANK1:  enable_next.bank1 = enable_reg.bank1 | write_data;
                OFF_ENABLE_BANK2:  enable_next.bank2 = enable_reg.bank2 | write_data;
                OFF_ENABLE_BASIC:  enable_next.basic = enable_reg.basic | write_data[7:0];
                OFF_DISABLE_BANK1: enable_next.bank1 = enable_reg.bank1 & ~write_data;
                OFF_DISABLE_BANK2: enable_next.bank2 = enable_reg.bank2 & ~write_data;
                OFF_DISABLE_BASIC: enable_next.basic = enable_reg.basic & ~write_data[7:0];
                default:           enable_next = enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (commit)
        begin
            enable_reg <= enable_next;
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && op == OP_WRITE && reg_offset == OFF_DISABLE_BANK1
        |=> (enable_reg.bank1 & $past(write_data)) == '0)
        else $error("Bank 1 disable left a bit enabled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        commit && op == OP_WRITE && reg_offset == OFF_ENABLE_BANK1
        |=> (enable_reg.bank1 & $past(write_data)) == $past(write_data))
        else $error("Bank 1 enable did not set every requested bit.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !commit |=> $stable(enable_reg))
        else $error("Enable masks changed without an item.");
`endif

endmodule

`default_nettype wire

// ----- src/icpd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module icpd_decode (
    input  wire logic             op,
    input  wire logic [3:0]       reg_offset,
    input  wire logic [31:0]      lines_bank1,
    input  wire logic [31:0]      lines_bank2,
    input  wire logic [7:0]       lines_basic,
    input  wire icpd_pkg::enable_t enable,
    output icpd_pkg::result_t     result
);
    import icpd_pkg::*;

    logic [31:0]         pend1;
    logic [31:0]         pend2;
    logic [7:0]          pend_basic;
    logic [63:0]         pend_all;
    logic [SC_COUNT-1:0] sc_pend;
    logic                sum1;
    logic                sum2;
    logic [31:0]         basic_word;
    logic [4:0]          top1;
    logic [4:0]          top2;
    logic [4:0]          top_sc;
    logic [4:0]          top_basic;

    always_comb
    begin
        pend1      = lines_bank1 & enable.bank1;
        pend2      = lines_bank2 & enable.bank2;
        pend_basic = lines_basic & enable.basic;
        pend_all   = {pend2, pend1};
        for (int i = 0; i < SC_COUNT; i++)
        begin
            sc_pend[i] = pend_all[SC_SOURCE[i][5:0]];
        end
        sum1       = (pend1 & ~SC_IN_BANK1) != '0;
        sum2       = (pend2 & ~SC_IN_BANK2) != '0;
        basic_word = {11'd0, sc_pend, sum2, sum1, pend_basic};
        top1       = top_bit32(pend1);
        top2       = top_bit32(pend2);
        top_sc     = top_bit32({21'd0, sc_pend});
        top_basic  = top_bit32({24'd0, pend_basic});
    end

    always_comb
    begin
        result.read_data = '0;
        if (op == OP_READ)
        begin
            unique case (reg_offset)
                OFF_BASIC_PEND:   result.read_data = basic_word;
                OFF_PEND_BANK1:   result.read_data = pend1;
                OFF_PEND_BANK2:   result.read_data = pend2;
                OFF_ENABLE_BANK1: result.read_data = enable.bank1;
                OFF_ENABLE_BANK2: result.read_data = enable.bank2;
                OFF_ENABLE_BASIC: result.read_data = {24'd0, enable.basic};
                default:          result.read_data = '0;
            endcase
        end

        result.irq_out    = basic_word != '0;
        result.next_irq   = '0;
        result.next_valid = 1'b0;
        if (sum1)
        begin
            result.next_irq   = {2'b00, top1};
            result.next_valid = 1'b1;
        end
        else if (sum2)
        begin
            result.next_irq   = {2'b01, top2};
            result.next_valid = 1'b1;
        end
        else if (sc_pend != '0)
        begin
            result.next_irq   = SC_SOURCE[top_sc[3:0]];
            result.next_valid = 1'b1;
        end
        else if (pend_basic != '0)
        begin
            result.next_irq   = {4'b1000, top_basic[2:0]};
            result.next_valid = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/interrupt_controller_priority_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake            Payload
// input    in_valid, in_stall   op, reg_offset, write_data, lines_bank1/2, lines_basic
// output   out_valid, out_stall read_data, irq_out, next_irq, next_valid
//
// One item per cycle unless stalled; items go from the input to the result register.
// Reset clears all enable masks and both valid flags.
// The enable masks are updated when an item moves from the input register
// into the result register, so each item sees its own write and those before it.
// A stalled result holds the input register, and in_stall rises only then.

module interrupt_controller_priority_decode (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [3:0]  reg_offset,
    input  wire logic [31:0] write_data,
    input  wire logic [31:0] lines_bank1,
    input  wire logic [31:0] lines_bank2,
    input  wire logic [7:0]  lines_basic,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      read_data,
    output logic             irq_out,
    output logic [6:0]       next_irq,
    output logic             next_valid
);
    import icpd_pkg::*;

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [3:0]  s1_offset_reg;
    logic [31:0] s1_wdata_reg;
    logic [31:0] s1_lines1_reg;
    logic [31:0] s1_lines2_reg;
    logic [7:0]  s1_lines_basic_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    enable_t     enable_next;
    logic        advance;
    logic        load;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    icpd_enable_regs u_enable (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .op          (s1_op_reg),
        .reg_offset  (s1_offset_reg),
        .write_data  (s1_wdata_reg),
        .enable_next (enable_next)
    );

    icpd_decode u_decode (
        .op          (s1_op_reg),
        .reg_offset  (s1_offset_reg),
        .lines_bank1 (s1_lines1_reg),
        .lines_bank2 (s1_lines2_reg),
        .lines_basic (s1_lines_basic_reg),
        .enable      (enable_next),
        .result      (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_op_reg          <= op;
            s1_offset_reg      <= reg_offset;
            s1_wdata_reg       <= write_data;
            s1_lines1_reg      <= lines_bank1;
            s1_lines2_reg      <= lines_bank2;
            s1_lines_basic_reg <= lines_basic;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign irq_out    = result_reg.irq_out;
    assign next_irq   = result_reg.next_irq;
    assign next_valid = result_reg.next_valid;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("Input stalled while the pipeline has room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.next_valid |-> result_reg.irq_out)
        else $error("Next interrupt reported without a request.");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_op_reg == OP_WRITE |=> result_reg.read_data == '0)
        else $error("Write item returned nonzero read data.");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_interrupt_controller_priority_decode.sv -----
`timescale 1ns / 1ps

module tb_interrupt_controller_priority_decode;

    import icpd_pkg::*;

    localparam logic [3:0] OFF_FIQ_CONTROL = 4'd3;
    localparam logic [3:0] OFF_LAST        = 4'd15;
    localparam int RANDOM_ITEMS = 950;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    class irq_status_tracker;
        logic [31:0] en_bank1;
        logic [31:0] en_bank2;
        logic [7:0]  en_basic;
        result_t     status_q[$];
        int          mismatches;

        function new();
            en_bank1   = '0;
            en_bank2   = '0;
            en_basic   = '0;
            mismatches = 0;
        endfunction

        function int top_set_bit(logic [31:0] v);
            int n;
            n = 0;
            for (int i = 0; i < 32; i++)
                if (v[i])
                    n = i;
            return n;
        endfunction

        // Applies a write to the enables first, then derives the status
        // that the updated enables give for this item.
        function void note_access(logic o, logic [3:0] off, logic [31:0] wd,
                                  logic [31:0] l1, logic [31:0] l2, logic [7:0] lb);
            logic [31:0] p1;
            logic [31:0] p2;
            logic [31:0] basic;
            logic [10:0] sc;
            logic [6:0]  src;
            result_t     r;
            if (o == OP_WRITE)
            begin
                case (off)
                    OFF_ENABLE_BANK1:  en_bank1 |= wd;
                    OFF_ENABLE_BANK2:  en_bank2 |= wd;
                    OFF_ENABLE_BASIC:  en_basic |= wd[7:0];
                    OFF_DISABLE_BANK1: en_bank1 &= ~wd;
                    OFF_DISABLE_BANK2: en_bank2 &= ~wd;
                    OFF_DISABLE_BASIC: en_basic &= ~wd[7:0];
                    default: ;
                endcase
            end
            p1 = l1 & en_bank1;
            p2 = l2 & en_bank2;
            for (int i = 0; i < SC_COUNT; i++)
            begin
                src   = SC_SOURCE[i];
                sc[i] = (src < 7'd32) ? p1[src[4:0]] : p2[src[4:0]];
            end
            basic = {11'b0, sc, |(p2 & ~SC_IN_BANK2), |(p1 & ~SC_IN_BANK1), lb & en_basic};
            r.read_data = '0;
            if (o == OP_READ)
            begin
                case (off)
                    OFF_BASIC_PEND:   r.read_data = basic;
                    OFF_PEND_BANK1:   r.read_data = p1;
                    OFF_PEND_BANK2:   r.read_data = p2;
                    OFF_ENABLE_BANK1: r.read_data = en_bank1;
                    OFF_ENABLE_BANK2: r.read_data = en_bank2;
                    OFF_ENABLE_BASIC: r.read_data = {24'b0, en_basic};
                    default:          r.read_data = '0;
                endcase
            end
            r.irq_out    = (basic != '0);
            r.next_irq   = '0;
            r.next_valid = 1'b0;
            if (basic[8])
            begin
                r.next_irq   = 7'(top_set_bit(p1));
                r.next_valid = 1'b1;
            end
            else if (basic[9])
            begin
                r.next_irq   = 7'(32 + top_set_bit(p2));
                r.next_valid = 1'b1;
            end
            else if (sc != '0)
            begin
                r.next_irq   = SC_SOURCE[top_set_bit({21'b0, sc})];
                r.next_valid = 1'b1;
            end
            else if (basic != '0)
            begin
                r.next_irq   = 7'(64 + top_set_bit(basic));
                r.next_valid = 1'b1;
            end
            status_q.push_back(r);
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (status_q.size() == 0)
            begin
                $error("unexpected result item: read_data %h", got.read_data);
                mismatches++;
                return;
            end
            want = status_q.pop_front();
            if (got.read_data !== want.read_data)
            begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                mismatches++;
            end
            if (got.irq_out !== want.irq_out)
            begin
                $error("irq_out: expected %b, got %b", want.irq_out, got.irq_out);
                mismatches++;
            end
            if (got.next_irq !== want.next_irq)
            begin
                $error("next_irq: expected %0d, got %0d", want.next_irq, got.next_irq);
                mismatches++;
            end
            if (got.next_valid !== want.next_valid)
            begin
                $error("next_valid: expected %b, got %b", want.next_valid, got.next_valid);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [3:0]  reg_offset;
    logic [31:0] write_data;
    logic [31:0] lines_bank1;
    logic [31:0] lines_bank2;
    logic [7:0]  lines_basic;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic        irq_out;
    logic [6:0]  next_irq;
    logic        next_valid;

    irq_status_tracker tracker;
    int send_mode    = 1;
    int recv_mode    = 1;
    int hold_request = 0;
    int cycle_count  = 0;

    interrupt_controller_priority_decode uut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_access(op, reg_offset, write_data,
                                    lines_bank1, lines_bank2, lines_basic);
            if (out_valid && !out_stall)
                tracker.check_status('{read_data, irq_out, next_irq, next_valid});
        end
    end

    function automatic int draw_idle(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 12);
            default: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
        endcase
    endfunction

    function automatic logic [31:0] random_lines(logic [31:0] sc_mask);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom & sc_mask;
            4:       return 32'b1 << $urandom_range(0, 31);
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    task automatic send_access(input logic o, input logic [3:0] off, input logic [31:0] wd,
                               input logic [31:0] l1, input logic [31:0] l2,
                               input logic [7:0] lb);
        int gap;
        gap = draw_idle(send_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        reg_offset  <= off;
        write_data  <= wd;
        lines_bank1 <= l1;
        lines_bank2 <= l2;
        lines_basic <= lb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_random_access();
        int          kind;
        logic        o;
        logic [3:0]  off;
        logic [31:0] wd;
        logic [7:0]  lb;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            o   = OP_WRITE;
            off = 4'($urandom_range(OFF_ENABLE_BANK1, OFF_DISABLE_BASIC));
        end
        else if (kind < 40)
        begin
            o   = OP_WRITE;
            off = 4'($urandom_range(OFF_BASIC_PEND, OFF_LAST));
        end
        else if (kind < 90)
        begin
            o   = OP_READ;
            off = 4'($urandom_range(OFF_BASIC_PEND, OFF_ENABLE_BASIC));
        end
        else
        begin
            o   = OP_READ;
            off = 4'($urandom_range(OFF_BASIC_PEND, OFF_LAST));
        end
        case ($urandom_range(0, 3))
            0:       wd = 32'b1 << $urandom_range(0, 31);
            1:       wd = $urandom & $urandom;
            default: wd = $urandom;
        endcase
        lb = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        send_access(o, off, wd, random_lines(SC_IN_BANK1), random_lines(SC_IN_BANK2), lb);
    endtask

    initial
    begin
        int n;
        out_stall <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
            end
            else
            begin
                n = draw_idle(recv_mode);
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            if ($urandom_range(0, 63) == 0)
                recv_mode = $urandom_range(0, 2);
        end
    end

    initial
    begin
        tracker = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_WRITE;
        reg_offset  <= OFF_BASIC_PEND;
        write_data  <= '0;
        lines_bank1 <= '0;
        lines_bank2 <= '0;
        lines_basic <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Everything starts disabled, so all-ones lines must show nothing pending.
        send_access(OP_READ,  OFF_ENABLE_BANK1,  '0, '1, '1, '1);
        send_access(OP_READ,  OFF_BASIC_PEND,    '0, '1, '1, '1);
        send_access(OP_WRITE, OFF_ENABLE_BASIC,  '1, '0, '0, '0);
        send_access(OP_READ,  OFF_ENABLE_BASIC,  '0, '0, '0, '0);
        send_access(OP_READ,  OFF_BASIC_PEND,    '0, '0, '0, '1);
        send_access(OP_WRITE, OFF_ENABLE_BANK2,  SC_IN_BANK2, '0, '1, '1);
        send_access(OP_READ,  OFF_BASIC_PEND,    '0, '0, '1, '0);
        send_access(OP_WRITE, OFF_ENABLE_BANK1,  SC_IN_BANK1, '1, '0, '0);
        send_access(OP_READ,  OFF_BASIC_PEND,    '0, '1, '1, '1);
        send_access(OP_WRITE, OFF_ENABLE_BANK2,  '1, '0, 32'h0000_0001, '0);
        send_access(OP_READ,  OFF_PEND_BANK2,    '0, SC_IN_BANK1, 32'h8000_0000, '1);
        send_access(OP_WRITE, OFF_ENABLE_BANK1,  '1, 32'h0000_0001, '0, '0);
        send_access(OP_READ,  OFF_PEND_BANK1,    '0, '1, '1, '1);
        send_access(OP_READ,  OFF_ENABLE_BANK2,  '0, '0, '0, '0);
        send_access(OP_READ,  OFF_FIQ_CONTROL,   '0, '1, '1, '1);
        send_access(OP_READ,  OFF_DISABLE_BANK1, '0, '1, '1, '1);
        send_access(OP_READ,  OFF_LAST,          '0, '1, '1, '1);
        send_access(OP_WRITE, OFF_BASIC_PEND,    '1, '1, '1, '1);
        send_access(OP_WRITE, OFF_FIQ_CONTROL,   '1, '1, '1, '1);
        send_access(OP_WRITE, OFF_LAST,          '1, '1, '1, '1);
        send_access(OP_WRITE, OFF_DISABLE_BASIC, '1, '1, '1, '1);
        send_access(OP_WRITE, OFF_DISABLE_BANK1, '1, '1, '1, '1);
        send_access(OP_WRITE, OFF_DISABLE_BANK2, '1, '1, '1, '1);
        send_access(OP_READ,  OFF_BASIC_PEND,    '0, '1, '1, '1);

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 64 == 0)
                send_mode = $urandom_range(0, 2);
            if (k == 256)
            begin
                // Back-to-back items against a long receiver hold fill the pipeline.
                send_mode    = 0;
                hold_request = HOLD_CYCLES;
            end
            if (k == 600)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (tracker.status_q.size() != 0);
            end
            send_random_access();
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.status_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
